// ----- hw/rtl/rfss_pkg.sv -----
package rfss_pkg;

  localparam int MaxPixels = 4096;
  localparam int AddrW     = $clog2(MaxPixels);
  localparam int CountW    = AddrW + 1;
  localparam int IndexW    = 12;
  localparam int ChanW     = 8;
  localparam int KindW     = 2;
  localparam int ColorW    = 2;
  localparam int CfgIdxW   = 2;
  localparam int CfgW      = 7;
  localparam int CfgReset  = 64;

  localparam int SumW       = 12;
  localparam int Div10Mul   = 3277;
  localparam int Div10Shift = 15;
  localparam int ProdW      = 24;

  localparam logic [KindW-1:0] KIND_FILL   = 2'd0;
  localparam logic [KindW-1:0] KIND_READ   = 2'd1;
  localparam logic [KindW-1:0] KIND_WRITE  = 2'd2;
  localparam logic [KindW-1:0] KIND_SMOOTH = 2'd3;

  localparam logic [ColorW-1:0] COLOR_RED   = 2'd0;
  localparam logic [ColorW-1:0] COLOR_GREEN = 2'd1;
  localparam logic [ColorW-1:0] COLOR_BLUE  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ColorW-1:0] fill_color;
    logic [IndexW-1:0] pixel_index;
    pixel_t            pix;
  } item_t;

  typedef struct packed {
    pixel_t pix;
    logic   bad_index;
  } result_t;

  typedef struct packed {
    logic load;
    logic item_wr;
    logic fill_wr;
    logic rd_item;
    logic sm_rd;
    logic out_load;
    logic cnt_clr;
  } cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             n_zero;
    logic             n_small;
    logic             cnt_last;
    logic             out_free;
  } status_t;

endpackage

// ----- hw/rtl/rfss_if.sv -----
interface rfss_item_if import rfss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [ColorW-1:0] fill_color;
  logic [IndexW-1:0] pixel_index;
  logic [ChanW-1:0]  red_in;
  logic [ChanW-1:0]  green_in;
  logic [ChanW-1:0]  blue_in;

  modport source (output valid, kind, fill_color, pixel_index, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, kind, fill_color, pixel_index, red_in, green_in, blue_in,
                output ready);
endinterface

interface rfss_result_if import rfss_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red_out;
  logic [ChanW-1:0] green_out;
  logic [ChanW-1:0] blue_out;
  logic             bad_index;

  modport source (output valid, red_out, green_out, blue_out, bad_index, input ready);
  modport sink (input valid, red_out, green_out, blue_out, bad_index, output ready);
endinterface

interface rfss_cfg_if import rfss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/rfss_ctrl.sv -----
module rfss_ctrl import rfss_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_FILL     = 3'd1;
  localparam logic [2:0] ST_RD_ISSUE = 3'd2;
  localparam logic [2:0] ST_RD_WAIT  = 3'd3;
  localparam logic [2:0] ST_SMOOTH   = 3'd4;
  localparam logic [2:0] ST_SM_DRAIN = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (status_i.kind)
            KIND_FILL: begin
              if (!status_i.n_zero) state_d = ST_FILL;
            end
            KIND_READ: begin
              state_d = ST_RD_ISSUE;
            end
            KIND_WRITE: begin
              cmd_o.item_wr = 1'b1;
            end
            KIND_SMOOTH: begin
              if (!status_i.n_small) state_d = ST_SMOOTH;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (status_i.cnt_last) state_d = ST_IDLE;
      end
      ST_RD_ISSUE: begin
        cmd_o.rd_item = 1'b1;
        state_d       = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_SMOOTH: begin
        cmd_o.sm_rd = 1'b1;
        if (status_i.cnt_last) state_d = ST_SM_DRAIN;
      end
      ST_SM_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/rfss_dp.sv -----
module rfss_dp import rfss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  item_t              item_i,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output result_t            result_o
);

  logic [CfgW-1:0]   width_q, height_q;
  logic [2*CfgW-1:0] area;
  logic [CountW-1:0] n_pix;
  logic [AddrW-1:0]  cnt_q;
  logic [IndexW-1:0] idx_q;
  logic [ColorW-1:0] color_q;
  logic              item_ok, idx_bad;
  pixel_t            mem_q [MaxPixels];
  pixel_t            rdata_q;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic              rd_v_q;
  logic [AddrW-1:0]  rd_k_q;
  pixel_t            left_q, self_q;
  pixel_t            smoothed, fill_pix, wdata;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic              out_valid_q;
  result_t           result_q;

  function automatic logic [ChanW-1:0] smooth_ch(logic [ChanW-1:0] l, logic [ChanW-1:0] s,
                                                 logic [ChanW-1:0] r);
    logic [SumW-1:0]  sum;
    logic [ProdW-1:0] prod;
    sum  = {s, 3'b000} + SumW'(l) + SumW'(r);
    prod = ProdW'(sum) * ProdW'(Div10Mul);
    return prod[Div10Shift+ChanW-1:Div10Shift];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(CfgReset);
      height_q <= CfgW'(CfgReset);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FRAME_WIDTH) width_q <= cfg_data_i;
      if (cfg_index_i == CFG_FRAME_HEIGHT) height_q <= cfg_data_i;
    end
  end

  assign area  = (2*CfgW)'(width_q) * (2*CfgW)'(height_q);
  assign n_pix = (area > (2*CfgW)'(MaxPixels)) ? CountW'(MaxPixels) : CountW'(area);

  assign item_ok = CountW'(item_i.pixel_index) < n_pix;
  assign idx_bad = CountW'(idx_q) >= n_pix;

  assign status_o.kind     = item_i.kind;
  assign status_o.n_zero   = n_pix == '0;
  assign status_o.n_small  = n_pix < CountW'(3);
  assign status_o.cnt_last = cnt_q == AddrW'(n_pix - CountW'(1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.fill_wr || cmd_i.sm_rd) begin
      cnt_q <= cnt_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q   <= item_i.pixel_index;
      color_q <= item_i.fill_color;
    end
  end

  assign rd_en   = cmd_i.rd_item || cmd_i.sm_rd;
  assign rd_addr = cmd_i.rd_item ? AddrW'(idx_q) : cnt_q;

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.sm_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_k_q <= cnt_q;
  end

  assign smoothed.red   = smooth_ch(left_q.red, self_q.red, rdata_q.red);
  assign smoothed.green = smooth_ch(left_q.green, self_q.green, rdata_q.green);
  assign smoothed.blue  = smooth_ch(left_q.blue, self_q.blue, rdata_q.blue);

  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      if (rd_k_q == '0) begin
        left_q <= rdata_q;
      end else if (rd_k_q == AddrW'(1)) begin
        self_q <= rdata_q;
      end else begin
        left_q <= smoothed;
        self_q <= rdata_q;
      end
    end
  end

  assign fill_pix.red   = (color_q == COLOR_RED) ? '1 : '0;
  assign fill_pix.green = (color_q == COLOR_GREEN) ? '1 : '0;
  assign fill_pix.blue  = (color_q == COLOR_BLUE) ? '1 : '0;

  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = fill_pix;
    if (cmd_i.fill_wr) begin
      we = 1'b1;
    end else if (rd_v_q && (rd_k_q > AddrW'(1))) begin
      we    = 1'b1;
      waddr = rd_k_q - AddrW'(1);
      wdata = smoothed;
    end else if (cmd_i.item_wr && item_ok) begin
      we    = 1'b1;
      waddr = AddrW'(item_i.pixel_index);
      wdata = item_i.pix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      result_q.pix       <= idx_bad ? '0 : rdata_q;
      result_q.bad_index <= idx_bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

// ----- hw/rtl/rgb_frame_store_smoother_top.sv -----
// RGB frame store of up to 4096 pixels with in-place smoothing, held in one memory with a
// single write port and a single registered read port. A pixel write is done as it is
// accepted, and a pixel read passes the index, read-data and result registers before its
// word is offered at the output. A fill walks the N pixels in use at one write per cycle,
// and a smooth streams the frame through the read port at one pixel per cycle and writes
// each result back behind the read; frames of fewer than three pixels skip smoothing. The
// frame size registers may only be written while the block is idle.
module rgb_frame_store_smoother_top import rfss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfss_item_if.sink  in_i,
  rfss_result_if.source out_o,
  rfss_cfg_if.sink   cfg_i
);

  item_t   item;
  result_t result;
  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;

  assign item.kind        = in_i.kind;
  assign item.fill_color  = in_i.fill_color;
  assign item.pixel_index = in_i.pixel_index;
  assign item.pix.red     = in_i.red_in;
  assign item.pix.green   = in_i.green_in;
  assign item.pix.blue    = in_i.blue_in;
  assign in_i.ready       = in_ready;
  assign cfg_i.ready      = 1'b1;

  assign out_o.valid     = out_valid;
  assign out_o.red_out   = result.pix.red;
  assign out_o.green_out = result.pix.green;
  assign out_o.blue_out  = result.pix.blue;
  assign out_o.bad_index = result.bad_index;

  rfss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rfss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .result_o    (result)
  );

endmodule

// ----- hw/rtl/rfss_checker.sv -----
module rfss_checker import rfss_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [ChanW-1:0] red_i,
  input logic [ChanW-1:0] green_i,
  input logic [ChanW-1:0] blue_i,
  input logic             bad_i
);

  // A stalled result word holds its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable({red_i, green_i, blue_i, bad_i}))
    else $error("result word changed while stalled");

  // An out-of-range read returns a black pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bad_i |-> red_i == '0 && green_i == '0 && blue_i == '0)
    else $error("bad index word carries pixel data");

  // A read passes through registers after it is accepted, so a new result never follows an accept directly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i))
    else $error("result appeared right after an accepted word");

  // While a read result is being produced the input side is held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("input was open while a read result was loaded");

endmodule

bind rgb_frame_store_smoother_top rfss_checker u_rfss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .red_i       (out_o.red_out),
  .green_i     (out_o.green_out),
  .blue_i      (out_o.blue_out),
  .bad_i       (out_o.bad_index)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import rfss_pkg::*;

  localparam logic [ColorW-1:0] ColorBlack = 2'd3;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned StallLimit = 30000;

  typedef enum int unsigned {
    SinkFree,
    SinkCoin,
    SinkSparse,
    SinkPeriodic
  } sink_mode_e;

  logic clk_i;
  logic rst_ni;

  rfss_item_if   in_if ();
  rfss_result_if res_if ();
  rfss_cfg_if    cfg_if ();

  rgb_frame_store_smoother_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  pixel_t      frame_copy [MaxPixels];
  bit          pixel_known [MaxPixels];
  int unsigned frame_w = CfgReset;
  int unsigned frame_h = CfgReset;
  result_t     read_words_q [$];
  int unsigned fail_count;
  int unsigned idle_cycles;
  bit          hold_off_req;
  bit          steady_send;
  int unsigned burst_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned pixels_in_use();
    int unsigned n;
    n = frame_w * frame_h;
    return (n > MaxPixels) ? MaxPixels : n;
  endfunction

  function automatic logic [ChanW-1:0] smooth_chan(logic [ChanW-1:0] lft, logic [ChanW-1:0] mid,
                                                   logic [ChanW-1:0] rgt);
    int unsigned acc;
    acc = 8 * mid + lft + rgt;
    return ChanW'(acc / 10);
  endfunction

  function automatic bit frame_complete(int unsigned n);
    for (int unsigned p = 0; p < n; p++) begin
      if (!pixel_known[AddrW'(p)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void apply_to_frame(item_t it);
    int unsigned n;
    result_t     word;
    n = pixels_in_use();
    case (it.kind)
      KIND_FILL: begin
        for (int unsigned p = 0; p < n; p++) begin
          frame_copy[AddrW'(p)].red   = (it.fill_color == COLOR_RED) ? 8'hff : 8'h00;
          frame_copy[AddrW'(p)].green = (it.fill_color == COLOR_GREEN) ? 8'hff : 8'h00;
          frame_copy[AddrW'(p)].blue  = (it.fill_color == COLOR_BLUE) ? 8'hff : 8'h00;
          pixel_known[AddrW'(p)] = 1'b1;
        end
      end
      KIND_READ: begin
        word = '0;
        if (it.pixel_index < n) begin
          word.pix = frame_copy[it.pixel_index];
        end else begin
          word.bad_index = 1'b1;
        end
        read_words_q.push_back(word);
      end
      KIND_WRITE: begin
        if (it.pixel_index < n) begin
          frame_copy[it.pixel_index] = it.pix;
          pixel_known[it.pixel_index] = 1'b1;
        end
      end
      default: begin
        for (int unsigned p = 1; p + 1 < n; p++) begin
          frame_copy[AddrW'(p)].red = smooth_chan(frame_copy[AddrW'(p - 1)].red,
                                                  frame_copy[AddrW'(p)].red,
                                                  frame_copy[AddrW'(p + 1)].red);
          frame_copy[AddrW'(p)].green = smooth_chan(frame_copy[AddrW'(p - 1)].green,
                                                    frame_copy[AddrW'(p)].green,
                                                    frame_copy[AddrW'(p + 1)].green);
          frame_copy[AddrW'(p)].blue = smooth_chan(frame_copy[AddrW'(p - 1)].blue,
                                                   frame_copy[AddrW'(p)].blue,
                                                   frame_copy[AddrW'(p + 1)].blue);
        end
      end
    endcase
  endfunction

  // Pixels that were never written hold no defined value, so a read of one becomes a write
  // and a smooth over an incomplete frame becomes a fill.
  function automatic item_t keep_defined(item_t it);
    int unsigned n;
    n = pixels_in_use();
    if (it.kind == KIND_READ && it.pixel_index < n && !pixel_known[it.pixel_index]) begin
      it.kind = KIND_WRITE;
    end else if (it.kind == KIND_SMOOTH && n >= 3 && !frame_complete(n)) begin
      it.kind = KIND_FILL;
    end
    return it;
  endfunction

  function automatic item_t pixel_item(logic [KindW-1:0] kind, logic [ColorW-1:0] color,
                                       logic [IndexW-1:0] idx, logic [ChanW-1:0] r,
                                       logic [ChanW-1:0] g, logic [ChanW-1:0] b);
    item_t it;
    it.kind        = kind;
    it.fill_color  = color;
    it.pixel_index = idx;
    it.pix.red     = r;
    it.pix.green   = g;
    it.pix.blue    = b;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned n;
    int unsigned pick;
    n = pixels_in_use();
    pick = $urandom_range(0, 99);
    if (pick < 40) it.kind = KIND_READ;
    else if (pick < 75) it.kind = KIND_WRITE;
    else if (pick < 88) it.kind = KIND_SMOOTH;
    else it.kind = KIND_FILL;
    it.fill_color = ColorW'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    if (pick < 7 && n > 0) it.pixel_index = IndexW'($urandom_range(0, n - 1));
    else if (pick < 9 && n < MaxPixels) it.pixel_index = IndexW'($urandom_range(n, MaxPixels - 1));
    else it.pixel_index = IndexW'($urandom_range(0, MaxPixels - 1));
    it.pix = (3*ChanW)'($urandom_range(0, 24'hffffff));
    if ($urandom_range(0, 5) == 0) it.pix.red = '1;
    if ($urandom_range(0, 5) == 0) it.pix.blue = '0;
    return it;
  endfunction

  task automatic send_item(item_t it);
    int unsigned gap;
    it = keep_defined(it);
    @(negedge clk_i);
    in_if.valid       <= 1'b1;
    in_if.kind        <= it.kind;
    in_if.fill_color  <= it.fill_color;
    in_if.pixel_index <= it.pixel_index;
    in_if.red_in      <= it.pix.red;
    in_if.green_in    <= it.pix.green;
    in_if.blue_in     <= it.pix.blue;
    do @(posedge clk_i); while (!in_if.ready);
    apply_to_frame(it);
    if (!steady_send) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 6);
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Fill and smooth return no word, so the frame may still be busy after the last read.
  task automatic wait_frame_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (read_words_q.size() != 0) @(posedge clk_i);
    repeat (pixels_in_use() + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == CFG_FRAME_WIDTH) frame_w = val;
    else if (idx == CFG_FRAME_HEIGHT) frame_h = val;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    wait_frame_idle();
    write_reg(CFG_FRAME_WIDTH, CfgW'(w));
    write_reg(CFG_FRAME_HEIGHT, CfgW'(h));
  endtask

  task automatic test_default_frame();
    steady_send = 1'b0;
    send_item(pixel_item(KIND_FILL, COLOR_RED, 0, 0, 0, 0));
    send_item(pixel_item(KIND_READ, 0, 12'd4095, 0, 0, 0));
    send_item(pixel_item(KIND_WRITE, 0, 12'd4095, 8'hff, 8'h00, 8'haa));
    send_item(pixel_item(KIND_READ, 0, 12'd4095, 0, 0, 0));
    send_item(pixel_item(KIND_SMOOTH, 0, 0, 0, 0, 0));
    send_item(pixel_item(KIND_READ, 0, 12'd4094, 0, 0, 0));
  endtask

  task automatic test_small_frame();
    set_frame(2, 2);
    steady_send = 1'b1;
    send_item(pixel_item(KIND_WRITE, 0, 0, 8'd255, 8'd0, 8'd128));
    send_item(pixel_item(KIND_WRITE, 0, 1, 8'd0, 8'd255, 8'd7));
    send_item(pixel_item(KIND_WRITE, 0, 2, 8'd255, 8'd255, 8'd255));
    send_item(pixel_item(KIND_WRITE, 0, 3, 8'd1, 8'd2, 8'd3));
    send_item(pixel_item(KIND_SMOOTH, 0, 0, 0, 0, 0));
    send_item(pixel_item(KIND_READ, 0, 1, 0, 0, 0));
    send_item(pixel_item(KIND_READ, 0, 2, 0, 0, 0));
    send_item(pixel_item(KIND_READ, 0, 4, 0, 0, 0));
    send_item(pixel_item(KIND_WRITE, 0, 12'd4095, 8'd9, 8'd9, 8'd9));
    send_item(pixel_item(KIND_FILL, COLOR_BLUE, 0, 0, 0, 0));
    send_item(pixel_item(KIND_READ, 0, 2, 0, 0, 0));
    send_item(pixel_item(KIND_FILL, ColorBlack, 0, 0, 0, 0));
    send_item(pixel_item(KIND_READ, 0, 3, 0, 0, 0));
  endtask

  task automatic test_single_pixel();
    set_frame(1, 1);
    send_item(pixel_item(KIND_WRITE, 0, 0, 8'd17, 8'd200, 8'd99));
    send_item(pixel_item(KIND_SMOOTH, 0, 0, 0, 0, 0));
    send_item(pixel_item(KIND_READ, 0, 0, 0, 0, 0));
  endtask

  task automatic test_empty_frame();
    set_frame(0, 64);
    send_item(pixel_item(KIND_FILL, COLOR_RED, 0, 0, 0, 0));
    send_item(pixel_item(KIND_WRITE, 0, 0, 8'd5, 8'd6, 8'd7));
    send_item(pixel_item(KIND_SMOOTH, 0, 0, 0, 0, 0));
    send_item(pixel_item(KIND_READ, 0, 0, 0, 0, 0));
  endtask

  task automatic test_oversize_frame();
    set_frame(127, 127);
    send_item(pixel_item(KIND_FILL, COLOR_GREEN, 0, 0, 0, 0));
    send_item(pixel_item(KIND_READ, 0, 12'd4095, 0, 0, 0));
  endtask

  task automatic load_frame();
    int unsigned n;
    n = pixels_in_use();
    if (n <= 12 && $urandom_range(0, 1) == 1) begin
      for (int unsigned p = 0; p < n; p++) begin
        send_item(pixel_item(KIND_WRITE, 0, IndexW'(p), ChanW'($urandom_range(0, 255)),
                             ChanW'($urandom_range(0, 255)), ChanW'($urandom_range(0, 255))));
      end
    end else begin
      send_item(pixel_item(KIND_FILL, ColorW'($urandom_range(0, 3)), 0, 0, 0, 0));
    end
  endtask

  task automatic test_random_frames();
    for (int unsigned ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_frame(1, $urandom_range(3, 20));
        1: set_frame(64, 64);
        default: set_frame($urandom_range(1, 12), $urandom_range(1, 6));
      endcase
      steady_send = ($urandom_range(0, 2) == 0);
      load_frame();
      repeat (15) send_item(random_item());
    end
  endtask

  task automatic test_backpressure();
    item_t it;
    set_frame(4, 4);
    steady_send = 1'b1;
    send_item(pixel_item(KIND_FILL, COLOR_GREEN, 0, 0, 0, 0));
    hold_off_req = 1'b1;
    repeat (24) begin
      it = random_item();
      it.kind = KIND_READ;
      send_item(it);
    end
    while (hold_off_req) @(posedge clk_i);
    wait_frame_idle();
    steady_send = 1'b0;
    repeat (8) send_item(random_item());
  endtask

  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned span;
    int unsigned tick;
    res_if.ready = 1'b0;
    span = 0;
    tick = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (span == 0) begin
          mode = sink_mode_e'($urandom_range(0, 3));
          span = $urandom_range(8, 80);
        end
        span--;
        tick++;
        case (mode)
          SinkFree:     res_if.ready <= 1'b1;
          SinkCoin:     res_if.ready <= 1'($urandom_range(0, 1));
          SinkSparse:   res_if.ready <= ($urandom_range(0, 3) == 0);
          default:      res_if.ready <= (tick % 4 != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_read_word
    result_t want;
    if (res_if.valid && res_if.ready) begin
      if (read_words_q.size() == 0) begin
        $error("unexpected word: red_out %0d green_out %0d blue_out %0d bad_index %0d",
               res_if.red_out, res_if.green_out, res_if.blue_out, res_if.bad_index);
        fail_count++;
      end else begin
        want = read_words_q.pop_front();
        if (res_if.red_out !== want.pix.red) begin
          $error("red_out: expected %0d, got %0d", want.pix.red, res_if.red_out);
          fail_count++;
        end
        if (res_if.green_out !== want.pix.green) begin
          $error("green_out: expected %0d, got %0d", want.pix.green, res_if.green_out);
          fail_count++;
        end
        if (res_if.blue_out !== want.pix.blue) begin
          $error("blue_out: expected %0d, got %0d", want.pix.blue, res_if.blue_out);
          fail_count++;
        end
        if (res_if.bad_index !== want.bad_index) begin
          $error("bad_index: expected %0d, got %0d", want.bad_index, res_if.bad_index);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_FILL;
    in_if.fill_color  = COLOR_RED;
    in_if.pixel_index = '0;
    in_if.red_in      = '0;
    in_if.green_in    = '0;
    in_if.blue_in     = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_FRAME_WIDTH;
    cfg_if.data       = '0;
    fail_count        = 0;
    idle_cycles       = 0;
    hold_off_req      = 1'b0;
    burst_left        = 0;
    rst_ni            = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_frame();
    test_small_frame();
    test_single_pixel();
    test_empty_frame();
    test_oversize_frame();
    test_random_frames();
    test_backpressure();
    wait_frame_idle();

    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
